// ===== rtl/ipwp_pkg.sv =====
// Package for the incremental path window penalty block: types, codes and helpers.
`timescale 1ns / 1ps

package ipwp_pkg;

  // Item codes
  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_NET    = 2'd1,
    ACT_COMMIT = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  // Configuration register indexes
  typedef enum logic {
    REG_WEIGHT_H = 1'b0,
    REG_WEIGHT_V = 1'b1
  } cfg_reg_e;

  localparam int unsigned LEN_W  = 31;
  localparam int unsigned HALF_W = 20;
  localparam int unsigned ACC_W  = 40;
  localparam int unsigned W_W    = 16;
  localparam int unsigned IDX_W  = 10;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_PEND,
    ST_PEN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [IDX_W-1:0]  path_index;
    logic              net_changed;
    logic [HALF_W-1:0] old_half_x;
    logic [HALF_W-1:0] new_half_x;
    logic [HALF_W-1:0] old_half_y;
    logic [HALF_W-1:0] new_half_y;
    logic              last_net_of_path;
    logic              last_path_of_move;
    logic [LEN_W-1:0]  load_low_bound;
    logic [LEN_W-1:0]  load_high_bound;
    logic [LEN_W-1:0]  load_length;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_path_index;
    logic [LEN_W-1:0]        pending_length;
    logic                    move_done;
    logic signed [ACC_W-1:0] penalty_delta;
  } out_req_t;

  // Clamp a widened sum back to the signed accumulator range
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > $signed({ACC_MAX[ACC_W-1], ACC_MAX})) r = ACC_MAX;
    else if (v < $signed({ACC_MIN[ACC_W-1], ACC_MIN})) r = ACC_MIN;
    else r = v[ACC_W-1:0];
    return r;
  endfunction

  // Distance outside the window, upper bound tested first
  function automatic logic [LEN_W-1:0] window_penalty(input logic [LEN_W-1:0] len,
                                                      input logic [LEN_W-1:0] lo,
                                                      input logic [LEN_W-1:0] hi);
    logic [LEN_W-1:0] r;
    if (len > hi) r = len - hi;
    else if (len < lo) r = lo - len;
    else r = '0;
    return r;
  endfunction

endpackage

// ===== rtl/incremental_path_window_penalty_top.sv =====
// Top level of the incremental path window penalty block.
// Flow: a path-ending net term passes states MUL, ACC, PEND and PEN, then waits in OUT
// while an earlier result stays stalled at the output, before it reaches the result register.
// Requests: one at a time; the next is taken once the sequencer is back in IDLE, after MUL for
// a load, after OUT for a path-ending net term and after ACC for any other request.
// Reset: weights return to 1.0, both accumulators clear; the path table is not cleared.
`timescale 1ns / 1ps

module incremental_path_window_penalty_top
  import ipwp_pkg::*;
#(
  parameter int unsigned PATH_COUNT      = 1024,
  parameter int unsigned HALF_PERIM_BITS = 20
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [W_W-1:0] cfg_wdata_i,
  input  in_req_t        in_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output out_req_t       out_o,
  output logic           out_valid_o,
  input  logic           out_stall_i
);

  localparam int unsigned AW = (PATH_COUNT > 1) ? $clog2(PATH_COUNT) : 1;
  localparam logic [HALF_W-1:0] HMASK = HALF_W'((64'(1) << HALF_PERIM_BITS) - 64'(1));

  // Path table: lengths as {current, pending}, bounds as {low, high}
  logic [2*LEN_W-1:0] len_mem [PATH_COUNT];
  logic [2*LEN_W-1:0] bnd_mem [PATH_COUNT];

  state_e state_q, state_d;
  in_req_t item_q;
  logic    idx_ok_q;
  logic [W_W-1:0] wh_q, wv_q;
  logic signed [ACC_W-1:0] len_acc_q, len_acc_d;
  logic signed [ACC_W-1:0] pen_acc_q, pen_acc_d;
  logic [LEN_W-1:0] rd_cur_q, rd_pend_q, rd_lo_q, rd_hi_q;
  logic [HALF_W+W_W-1:0] pnx_q, pox_q, pny_q, poy_q;
  logic [LEN_W-1:0] pend_q, pen_new_q, pen_old_q;
  out_req_t out_q;
  logic     out_valid_q;

  logic [AW-1:0] addr;
  logic [LEN_W-1:0] cur_eff, lo_eff, hi_eff;
  logic signed [LEN_W-1:0] delta;
  logic signed [ACC_W:0]   len_sum, pen_sum, pend_sum;
  logic signed [LEN_W:0]   pen_diff;
  logic signed [ACC_W-1:0] pen_next;
  logic [LEN_W-1:0] pend_sat;
  logic accept, out_free;

  assign addr     = AW'(item_q.path_index);
  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign cur_eff  = idx_ok_q ? rd_cur_q : '0;
  assign lo_eff   = idx_ok_q ? rd_lo_q  : '0;
  assign hi_eff   = idx_ok_q ? rd_hi_q  : '0;

  // Weight registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wh_q <= W_W'(256);
      wv_q <= W_W'(256);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_WEIGHT_H: wh_q <= cfg_wdata_i;
        REG_WEIGHT_V: wv_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q   <= in_i;
      idx_ok_q <= 32'(in_i.path_index) < PATH_COUNT;
    end
  end

  // Table reads, registered
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      {rd_cur_q, rd_pend_q} <= len_mem[addr];
      {rd_lo_q, rd_hi_q}    <= bnd_mem[addr];
    end
  end

  // Table writes; out-of-range paths drop their writes
  always_ff @(posedge clk_i) begin
    if (idx_ok_q) begin
      if (state_q == ST_MUL && action_e'(item_q.action) == ACT_LOAD) begin
        bnd_mem[addr] <= {item_q.load_low_bound, item_q.load_high_bound};
        len_mem[addr] <= {item_q.load_length, item_q.load_length};
      end else if (state_q == ST_ACC && action_e'(item_q.action) == ACT_COMMIT) begin
        len_mem[addr] <= {rd_pend_q, rd_pend_q};
      end else if (state_q == ST_PEND) begin
        len_mem[addr] <= {rd_cur_q, pend_sat};
      end
    end
  end

  // Weighted half-perimeter products
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      pnx_q <= (HALF_W+W_W)'(wh_q) * (HALF_W+W_W)'(item_q.new_half_x & HMASK);
      pox_q <= (HALF_W+W_W)'(wh_q) * (HALF_W+W_W)'(item_q.old_half_x & HMASK);
      pny_q <= (HALF_W+W_W)'(wv_q) * (HALF_W+W_W)'(item_q.new_half_y & HMASK);
      poy_q <= (HALF_W+W_W)'(wv_q) * (HALF_W+W_W)'(item_q.old_half_y & HMASK);
    end
  end

  // Sum the truncated products and fold them into the length change
  assign delta = $signed(LEN_W'(pnx_q[HALF_W+W_W-1:8])) - $signed(LEN_W'(pox_q[HALF_W+W_W-1:8]))
               + $signed(LEN_W'(pny_q[HALF_W+W_W-1:8])) - $signed(LEN_W'(poy_q[HALF_W+W_W-1:8]));
  assign len_sum = (ACC_W+1)'(len_acc_q) + (ACC_W+1)'(delta);

  // Pending length, clamped to the length range
  assign pend_sum = $signed((ACC_W+1)'(cur_eff)) + (ACC_W+1)'(len_acc_q);
  always_comb begin
    if (pend_sum < 0) pend_sat = '0;
    else if (pend_sum > $signed((ACC_W+1)'(LEN_MAX))) pend_sat = LEN_MAX;
    else pend_sat = pend_sum[LEN_W-1:0];
  end

  // Penalty change of this path
  assign pen_diff = $signed({1'b0, pen_new_q}) - $signed({1'b0, pen_old_q});
  assign pen_sum  = (ACC_W+1)'(pen_acc_q) + (ACC_W+1)'(pen_diff);
  assign pen_next = sat_acc(pen_sum);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PEND) pend_q <= pend_sat;
    if (state_q == ST_PEN) begin
      pen_new_q <= window_penalty(pend_q, lo_eff, hi_eff);
      pen_old_q <= window_penalty(cur_eff, lo_eff, hi_eff);
    end
  end

  // Sequencer and accumulators
  always_comb begin
    state_d   = state_q;
    len_acc_d = len_acc_q;
    pen_acc_d = pen_acc_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_MUL;
      ST_MUL: begin
        if (action_e'(item_q.action) == ACT_LOAD) state_d = ST_IDLE;
        else state_d = ST_ACC;
      end
      ST_ACC: begin
        state_d = ST_IDLE;
        if (action_e'(item_q.action) == ACT_NET) begin
          if (item_q.net_changed) len_acc_d = sat_acc(len_sum);
          if (item_q.last_net_of_path) state_d = ST_PEND;
        end
      end
      ST_PEND: begin
        len_acc_d = '0;
        state_d   = ST_PEN;
      end
      ST_PEN: state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          pen_acc_d = item_q.last_path_of_move ? '0 : pen_next;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      len_acc_q <= '0;
      pen_acc_q <= '0;
    end else begin
      state_q   <= state_d;
      len_acc_q <= len_acc_d;
      pen_acc_q <= pen_acc_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      out_q.out_path_index <= item_q.path_index;
      out_q.pending_length <= pend_q;
      out_q.move_done      <= item_q.last_path_of_move;
      out_q.penalty_delta  <= pen_next;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/ipwp_checker.sv =====
// Port-level checks for the incremental path window penalty block, with its bind.
`timescale 1ns / 1ps

module ipwp_checker
  import ipwp_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input in_req_t  in_i,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input out_req_t out_o,
  input logic     out_valid_o,
  input logic     out_stall_i
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed");

  // An accepted request occupies the block for the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("request accepted back to back");

  // A new result only comes out of a busy block
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while idle");

  // A load never produces a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && action_e'(in_i.action) == ACT_LOAD |=> !$rose(out_valid_o) ##1 !$rose(out_valid_o))
    else $error("load produced a result");

endmodule

bind incremental_path_window_penalty_top ipwp_checker u_ipwp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_i        (in_i),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_o       (out_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

// ===== bench/path_penalty_checker.sv =====
// Checker for the path window penalty block: predicts path results and compares them.
`timescale 1ns / 1ps

module path_penalty_checker
  import ipwp_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [W_W-1:0] cfg_wdata_i,
  input  in_req_t        in_i,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  out_req_t       out_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  output int             fail_count_o,
  output int             awaited_o
);

  localparam int unsigned TABLE_DEPTH = 1 << IDX_W;
  localparam longint ACC_HI = 64'sd549755813887;
  localparam longint ACC_LO = -64'sd549755813888;
  localparam longint LEN_HI = 64'sd2147483647;

  // Shadow copy of the path table, accumulators and weights
  logic [LEN_W-1:0]        cur_len  [TABLE_DEPTH];
  logic [LEN_W-1:0]        pend_len [TABLE_DEPTH];
  logic [LEN_W-1:0]        low_bnd  [TABLE_DEPTH];
  logic [LEN_W-1:0]        high_bnd [TABLE_DEPTH];
  logic signed [ACC_W-1:0] len_change;
  logic signed [ACC_W-1:0] pen_change;
  logic [W_W-1:0]          wt_h;
  logic [W_W-1:0]          wt_v;

  out_req_t path_result_q[$];
  int       mismatches;

  // Truncated product of a Q8.8 weight and a half-perimeter
  function automatic longint scaled_half(input logic [W_W-1:0] w,
                                         input logic [HALF_W-1:0] h);
    logic [W_W+HALF_W-1:0] prod;
    prod = (W_W+HALF_W)'(w) * (W_W+HALF_W)'(h);
    return longint'(prod >> 8);
  endfunction

  // Clamp to the signed 40-bit accumulator range
  function automatic logic signed [ACC_W-1:0] clamp_acc(input longint v);
    longint c;
    c = v;
    if (c > ACC_HI) c = ACC_HI;
    if (c < ACC_LO) c = ACC_LO;
    return c[ACC_W-1:0];
  endfunction

  // Distance of a length outside its window, upper bound first
  function automatic longint window_excess(input longint len, input longint lo,
                                           input longint hi);
    if (len > hi) return len - hi;
    if (len < lo) return lo - len;
    return 0;
  endfunction

  // Advance the shadow state by one accepted request
  task automatic update_path_table(input in_req_t r);
    longint   delta;
    longint   cur;
    longint   lo;
    longint   hi;
    longint   pend;
    out_req_t res;
    case (r.action)
      ACT_LOAD: begin
        low_bnd[r.path_index]  = r.load_low_bound;
        high_bnd[r.path_index] = r.load_high_bound;
        cur_len[r.path_index]  = r.load_length;
        pend_len[r.path_index] = r.load_length;
      end
      ACT_COMMIT: begin
        cur_len[r.path_index] = pend_len[r.path_index];
      end
      ACT_NET: begin
        if (r.net_changed) begin
          delta = scaled_half(wt_h, r.new_half_x) - scaled_half(wt_h, r.old_half_x)
                + scaled_half(wt_v, r.new_half_y) - scaled_half(wt_v, r.old_half_y);
          len_change = clamp_acc(longint'(len_change) + delta);
        end
        if (r.last_net_of_path) begin
          cur  = longint'(cur_len[r.path_index]);
          lo   = longint'(low_bnd[r.path_index]);
          hi   = longint'(high_bnd[r.path_index]);
          pend = cur + longint'(len_change);
          if (pend < 0) pend = 0;
          if (pend > LEN_HI) pend = LEN_HI;
          pend_len[r.path_index] = pend[LEN_W-1:0];
          len_change = '0;
          pen_change = clamp_acc(longint'(pen_change) + window_excess(pend, lo, hi)
                                 - window_excess(cur, lo, hi));
          res.out_path_index = r.path_index;
          res.pending_length = pend[LEN_W-1:0];
          res.move_done      = r.last_path_of_move;
          res.penalty_delta  = pen_change;
          path_result_q.push_back(res);
          if (r.last_path_of_move) pen_change = '0;
        end
      end
      default: begin
      end
    endcase
  endtask

  // Compare one delivered result with the oldest prediction
  task automatic check_result(input out_req_t got);
    out_req_t want;
    if (path_result_q.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: unexpected result path %0d pend %0d done %0b delta %0d", $realtime,
                 got.out_path_index, got.pending_length, got.move_done, got.penalty_delta);
      mismatches++;
    end else begin
      want = path_result_q.pop_front();
      if (got.out_path_index !== want.out_path_index ||
          got.pending_length !== want.pending_length ||
          got.move_done !== want.move_done ||
          got.penalty_delta !== want.penalty_delta) begin
        if (mismatches < 10)
          $display("%0t: result mismatch: got path %0d pend %0d done %0b delta %0d, %s",
                   $realtime, got.out_path_index, got.pending_length, got.move_done,
                   got.penalty_delta,
                   $sformatf("want path %0d pend %0d done %0b delta %0d",
                             want.out_path_index, want.pending_length, want.move_done,
                             want.penalty_delta));
        mismatches++;
      end
    end
  endtask

  // Watch configuration, requests and results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_change = '0;
      pen_change = '0;
      wt_h       = 16'd256;
      wt_v       = 16'd256;
      mismatches = 0;
      path_result_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_WEIGHT_H) wt_h = cfg_wdata_i;
        else wt_v = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) update_path_table(in_i);
      if (out_valid_i && !out_stall_i) check_result(out_i);
    end
    fail_count_o <= mismatches;
    awaited_o    <= path_result_q.size();
  end

endmodule

// ===== bench/incremental_path_window_penalty_top_test.sv =====
// Testbench top for the path window penalty block: stimulus, idling and verdict.
`timescale 1ns / 1ps

module incremental_path_window_penalty_top_test;
  import ipwp_pkg::*;

  localparam logic [HALF_W-1:0] HMAX = {HALF_W{1'b1}};

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           cfg_we    = 1'b0;
  logic           cfg_idx   = 1'b0;
  logic [W_W-1:0] cfg_wdata = '0;
  in_req_t        in_req    = '0;
  logic           in_valid  = 1'b0;
  logic           in_stall;
  out_req_t       out_rsp;
  logic           out_valid;
  logic           out_stall = 1'b0;

  int send_idle_pct = 30;
  int recv_idle_pct = 52;
  int fail_count;
  int awaited;
  int issued;
  int loaded_q[$];
  bit is_loaded[1 << IDX_W];

  incremental_path_window_penalty_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_req),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .out_o       (out_rsp),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall)
  );

  path_penalty_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_i         (in_req),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .out_i        (out_rsp),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .fail_count_o (fail_count),
    .awaited_o    (awaited)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Fill every field with random bits
  function automatic in_req_t noise_req();
    logic [191:0] bits;
    bits = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    return bits[$bits(in_req_t)-1:0];
  endfunction

  // Present one request and hold it until accepted
  task automatic push_req(input in_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_req   <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (r.action != ACT_NONE) issued++;
  endtask

  // Drop valid and wait until every predicted result has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_weights(input logic [W_W-1:0] h, input logic [W_W-1:0] v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_WEIGHT_H;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_idx   <= REG_WEIGHT_V;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic load_path(input int p, input logic [LEN_W-1:0] lo,
                           input logic [LEN_W-1:0] hi, input logic [LEN_W-1:0] len);
    in_req_t r;
    r = noise_req();
    r.action          = ACT_LOAD;
    r.path_index      = IDX_W'(p);
    r.load_low_bound  = lo;
    r.load_high_bound = hi;
    r.load_length     = len;
    push_req(r);
    if (!is_loaded[p]) begin
      is_loaded[p] = 1'b1;
      loaded_q.push_back(p);
    end
  endtask

  task automatic send_net(input int p, input bit chg, input logic [HALF_W-1:0] ox,
                          input logic [HALF_W-1:0] nx, input logic [HALF_W-1:0] oy,
                          input logic [HALF_W-1:0] ny, input bit last_net,
                          input bit last_path);
    in_req_t r;
    r = noise_req();
    r.action            = ACT_NET;
    r.path_index        = IDX_W'(p);
    r.net_changed       = chg;
    r.old_half_x        = ox;
    r.new_half_x        = nx;
    r.old_half_y        = oy;
    r.new_half_y        = ny;
    r.last_net_of_path  = last_net;
    r.last_path_of_move = last_path;
    push_req(r);
  endtask

  task automatic commit_path(input int p);
    in_req_t r;
    r = noise_req();
    r.action     = ACT_COMMIT;
    r.path_index = IDX_W'(p);
    push_req(r);
  endtask

  // Mostly well-formed moves over loaded paths, with loads, commits and noise mixed in
  task automatic run_random(input int target);
    int               pick;
    int               n_paths;
    int               n_nets;
    int               p;
    bit               ends_move;
    bit               last_net;
    bit               last_path;
    bit               paused;
    logic [LEN_W-1:0] lo;
    logic [LEN_W-1:0] hi;
    logic [LEN_W-1:0] len;
    in_req_t          r;
    issued = 0;
    paused = 1'b0;
    while (issued < target) begin
      // Hold off once mid-phase until the block has caught up
      if (!paused && issued >= target / 2) begin
        drain_results();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (loaded_q.size() == 0 || pick < 15) begin
        if ($urandom_range(3) == 0) begin
          lo  = LEN_W'($urandom());
          hi  = LEN_W'($urandom());
          len = LEN_W'($urandom());
        end else begin
          lo  = LEN_W'($urandom_range(4_000_000));
          hi  = LEN_W'(lo + $urandom_range(2_000_000));
          len = LEN_W'($urandom_range(6_000_000));
          if ($urandom_range(7) == 0) {lo, hi} = {hi, lo};
        end
        load_path($urandom_range(1023), lo, hi, len);
      end else if (pick < 75) begin
        n_paths   = $urandom_range(1, 4);
        ends_move = ($urandom_range(9) != 0);
        for (int k = 0; k < n_paths; k++) begin
          p      = loaded_q[$urandom_range(loaded_q.size() - 1)];
          n_nets = $urandom_range(1, 5);
          for (int n = 0; n < n_nets; n++) begin
            last_net  = (n == n_nets - 1);
            last_path = last_net ? (ends_move && k == n_paths - 1)
                                 : ($urandom_range(9) == 0);
            send_net(p, $urandom_range(3) != 0, HALF_W'($urandom()), HALF_W'($urandom()),
                     HALF_W'($urandom()), HALF_W'($urandom()), last_net, last_path);
          end
        end
      end else if (pick < 88) begin
        commit_path(loaded_q[$urandom_range(loaded_q.size() - 1)]);
      end else begin
        // Noise: unused code, or a stray net term that ends no path
        r = noise_req();
        if ($urandom_range(1) == 0) begin
          r.action = ACT_NONE;
        end else begin
          r.action           = ACT_NET;
          r.last_net_of_path = 1'b0;
        end
        push_req(r);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at unit weights
    set_weights(16'd256, 16'd256);
    load_path(0, '0, LEN_MAX, '0);
    load_path(1023, LEN_MAX, LEN_MAX, LEN_MAX);
    load_path('h155, 31'd1000, 31'd2000, 31'd1500);
    load_path('h2AA, 31'd5000, 31'd100, 31'd3000);
    send_net('h155, 1'b1, '0, HMAX, HMAX, '0, 1'b0, 1'b0);
    send_net('h155, 1'b0, HMAX, '0, 20'd123, 20'd4567, 1'b0, 1'b1);
    send_net('h155, 1'b1, 20'd100, 20'd900, 20'd50, 20'd50, 1'b1, 1'b0);
    send_net('h2AA, 1'b1, 20'd2000, '0, '0, '0, 1'b1, 1'b1);
    commit_path('h155);
    push_req('1);
    send_net(1023, 1'b1, '0, HMAX, '0, HMAX, 1'b1, 1'b1);
    send_net(0, 1'b1, HMAX, '0, HMAX, '0, 1'b1, 1'b1);
    commit_path(0);
    commit_path(1023);
    send_net(0, 1'b0, '0, '0, '0, '0, 1'b1, 1'b1);
    send_net(1023, 1'b1, HMAX, '0, '0, '0, 1'b1, 1'b1);

    // Random phases, idling swapped, then none
    set_weights(W_W'($urandom_range(65535)), W_W'($urandom_range(65535)));
    run_random(180);
    set_weights(16'd0, 16'hFFFF);
    send_idle_pct = 52;
    recv_idle_pct <= 30;
    run_random(180);
    set_weights(16'hFFFF, 16'd0);
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    run_random(180);

    // Drive the penalty sum past its upper limit over one long move
    set_weights(16'hFFFF, 16'hFFFF);
    load_path('h2D5, '0, '0, '0);
    for (int k = 0; k < 260; k++) begin
      for (int n = 0; n < 4; n++)
        send_net('h2D5, 1'b1, '0, HMAX, '0, HMAX, n == 3, n == 3 && k == 259);
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && awaited == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
